>>> rtl/dpb_pkg.sv
`default_nettype none
package dpb_pkg;

    localparam int MAX_DENSITY = 8;
    localparam int IDX_W       = $clog2(MAX_DENSITY);

    localparam int ROW_W   = 10;
    localparam int SIZE_W  = 16;
    localparam int DENS_W  = 4;
    localparam int ROOT_W  = 16;
    localparam int COORD_W = 19;

    localparam int IMG_W   = 13;
    localparam int FEAT_W  = 11;
    localparam int STEP_W  = 16;
    localparam int OFS_W   = 8;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 8;

    // divider datapath
    localparam int DVD_W = 50;
    localparam int DVS_W = 21;
    localparam int CNT_W = 6;
    localparam int QUO_W = 43;

    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [QUO_W-1:0] ONE_Q    = QUO_W'(65536);
    localparam logic signed [QUO_W-1:0] SAT_HI_Q = QUO_W'(262143);
    localparam logic signed [QUO_W-1:0] SAT_LO_Q = -QUO_W'(262144);

    typedef enum logic [CIDX_W-1:0] {
        REG_IMAGE_WIDTH   = 8'd0,
        REG_IMAGE_HEIGHT  = 8'd1,
        REG_FMAP_WIDTH    = 8'd2,
        REG_FMAP_HEIGHT   = 8'd3,
        REG_STEP_X        = 8'd4,
        REG_STEP_Y        = 8'd5,
        REG_CENTER_OFFSET = 8'd6,
        REG_CLIP_ENABLE   = 8'd7
    } cfg_index_t;

    typedef struct packed {
        logic [IMG_W-1:0]  image_width;
        logic [IMG_W-1:0]  image_height;
        logic [FEAT_W-1:0] fmap_width;
        logic [FEAT_W-1:0] fmap_height;
        logic [STEP_W-1:0] step_x;
        logic [STEP_W-1:0] step_y;
        logic [OFS_W-1:0]  center_offset;
        logic              clip_enable;
    } cfg_t;

    // floor quotient with nonnegative remainder
    typedef struct packed {
        logic signed [QUO_W-1:0] q;
        logic [DVS_W-1:0]        r;
    } qr_t;

    typedef struct packed {
        qr_t               x0;
        qr_t               x1;
        qr_t               y0;
        qr_t               y1;
        qr_t               ix;
        qr_t               iy;
        logic [DVS_W-1:0]  dx;
        logic [DVS_W-1:0]  dy;
        logic [DENS_W-1:0] dens;
    } box_job_t;

endpackage
`default_nettype wire

>>> rtl/dpb_div.sv
`default_nettype none
module dpb_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [dpb_pkg::DVD_W-1:0]  dividend,
    input  wire logic [dpb_pkg::DVS_W-1:0]  divisor,
    input  wire logic [dpb_pkg::CNT_W-1:0]  count,
    output logic                            done,
    output logic [dpb_pkg::DVD_W-1:0]       quotient,
    output logic [dpb_pkg::DVS_W-1:0]       remainder
);
    import dpb_pkg::*;

    logic [DVD_W-1:0] acc_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           ge;

    // restoring, one quotient bit per cycle; dividend arrives left-aligned
    assign trial = {rem_reg, acc_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= count;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            acc_reg <= {acc_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = acc_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

>>> rtl/dpb_front.sv
`default_nettype none
module dpb_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [dpb_pkg::ROW_W-1:0]   s_cell_row,
    input  wire logic [dpb_pkg::ROW_W-1:0]   s_cell_col,
    input  wire logic [dpb_pkg::SIZE_W-1:0]  s_box_size,
    input  wire logic [dpb_pkg::DENS_W-1:0]  s_density,
    input  wire logic [dpb_pkg::ROOT_W-1:0]  s_ratio_root,
    input  wire dpb_pkg::cfg_t               cfg,
    input  wire logic                        cfg_wr,
    output logic                             job_valid,
    input  wire logic                        job_ready,
    output dpb_pkg::box_job_t                job
);
    import dpb_pkg::*;

    localparam int STEPQ_W = IMG_W + 16;          // step in Q.16 pixels
    localparam int AVG_W   = STEPQ_W - 16;
    localparam int ORG_W   = ROW_W + OFS_W;
    localparam int SPLIT   = 15;
    localparam int PLO_W   = ORG_W + SPLIT;
    localparam int PHI_W   = ORG_W + STEPQ_W - SPLIT;
    localparam int CX_W    = ORG_W + STEPQ_W;
    localparam int HH_W    = SIZE_W + 31;
    localparam int HW_W    = SIZE_W + ROOT_W + 7;
    localparam int OFF_W   = AVG_W + 23;
    localparam int SN_W    = DVD_W + 1;

    typedef enum logic [4:0] {
        F_IDLE, F_SX, F_SX_W, F_SY, F_SY_W, F_AVG, F_SHIFT, F_SHIFT_W,
        F_MULX_LO, F_MULX_HI, F_MULY_LO, F_MULY_HI, F_HH, F_HH_W,
        F_DC, F_PREP, F_GO, F_WAIT, F_PUSH
    } fstate_t;

    typedef enum logic [2:0] {
        OP_X0, OP_X1, OP_Y0, OP_Y1, OP_IX, OP_IY
    } fd_op_t;

    fstate_t state_reg;
    fd_op_t  op_reg;
    logic    steps_ok_reg;

    logic [ROW_W-1:0]   row_reg, col_reg;
    logic [SIZE_W-1:0]  bsz_reg;
    logic [DENS_W-1:0]  dens_reg;
    logic [ROOT_W-1:0]  rr_reg;
    logic [STEPQ_W-1:0] sx_reg, sy_reg;
    logic [AVG_W-1:0]   avg_reg, shift_reg;
    logic [PLO_W-1:0]   prod_reg;
    logic [CX_W-1:0]    cx_reg, cy_reg;
    logic [HH_W-1:0]    hh_reg;
    logic [HW_W-1:0]    hw_reg;
    logic signed [SN_W-1:0] dcx_reg, dcy_reg, num_reg;
    qr_t res_reg [6];

    logic [IMG_W-1:0]  iw_nz, ih_nz;
    logic [FEAT_W-1:0] fw_nz, fh_nz;
    logic [DVS_W-1:0]  dx, dy, dsel;
    logic              derive;
    logic [ORG_W-1:0]  ax, ay;
    logic [PHI_W-1:0]  mhi_x, mhi_y;
    logic [PLO_W-1:0]  mlo_x, mlo_y;
    logic [OFF_W-1:0]  off;
    logic [SN_W-1:0]   num_neg;
    logic signed [SN_W-1:0] num_next;

    logic             div_start, div_done;
    logic [DVD_W-1:0] div_dvd, div_quo;
    logic [DVS_W-1:0] div_dvs, div_rem;
    logic [CNT_W-1:0] div_cnt;

    logic [QUO_W-1:0] qu;
    qr_t              fix;

    assign iw_nz  = (cfg.image_width == '0) ? IMG_W'(1) : cfg.image_width;
    assign ih_nz  = (cfg.image_height == '0) ? IMG_W'(1) : cfg.image_height;
    assign fw_nz  = (cfg.fmap_width == '0) ? FEAT_W'(1) : cfg.fmap_width;
    assign fh_nz  = (cfg.fmap_height == '0) ? FEAT_W'(1) : cfg.fmap_height;
    assign dx     = {iw_nz, 8'b0};
    assign dy     = {ih_nz, 8'b0};
    assign derive = (cfg.step_x == '0) || (cfg.step_y == '0);

    // (idx << 8) + offset is a plain concatenation
    assign ax    = {col_reg, cfg.center_offset};
    assign ay    = {row_reg, cfg.center_offset};
    assign mlo_x = ax * sx_reg[SPLIT-1:0];
    assign mlo_y = ay * sy_reg[SPLIT-1:0];
    assign mhi_x = ax * sx_reg[STEPQ_W-1:SPLIT];
    assign mhi_y = ay * sy_reg[STEPQ_W-1:SPLIT];
    assign off   = {avg_reg - shift_reg, 23'b0};

    always_comb begin
        unique case (op_reg)
            OP_X0:   num_next = dcx_reg - $signed(SN_W'(hw_reg));
            OP_X1:   num_next = dcx_reg + $signed(SN_W'(hw_reg));
            OP_Y0:   num_next = dcy_reg - $signed(SN_W'(hh_reg));
            OP_Y1:   num_next = dcy_reg + $signed(SN_W'(hh_reg));
            default: num_next = $signed(SN_W'({shift_reg, 24'b0}));
        endcase
    end

    assign dsel    = (op_reg == OP_X0 || op_reg == OP_X1 || op_reg == OP_IX) ? dx : dy;
    assign num_neg = -num_reg;

    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = dsel;
        div_cnt   = CNT_W'(DVD_W);
        unique case (state_reg)
            F_SX: begin
                div_start = derive;
                div_dvd   = {iw_nz, {(DVD_W-IMG_W){1'b0}}};
                div_dvs   = DVS_W'(fw_nz);
                div_cnt   = CNT_W'(STEPQ_W);
            end
            F_SY: begin
                div_start = 1'b1;
                div_dvd   = {ih_nz, {(DVD_W-IMG_W){1'b0}}};
                div_dvs   = DVS_W'(fh_nz);
                div_cnt   = CNT_W'(STEPQ_W);
            end
            F_SHIFT: begin
                div_start = 1'b1;
                div_dvd   = {avg_reg, {(DVD_W-AVG_W){1'b0}}};
                div_dvs   = DVS_W'(dens_reg);
                div_cnt   = CNT_W'(AVG_W);
            end
            F_HH: begin
                div_start = 1'b1;
                div_dvd   = {bsz_reg, {(DVD_W-SIZE_W){1'b0}}};
                div_dvs   = DVS_W'(rr_reg);
                div_cnt   = CNT_W'(HH_W);
            end
            F_GO: begin
                div_start = 1'b1;
                div_dvd   = num_reg[SN_W-1] ? num_neg[DVD_W-1:0] : num_reg[DVD_W-1:0];
            end
            default: ;
        endcase
    end

    dpb_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .count     (div_cnt),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // turn the magnitude quotient into a floor quotient
    assign qu = div_quo[QUO_W-1:0];
    always_comb begin
        if (!num_reg[SN_W-1]) begin
            fix.q = $signed(qu);
            fix.r = div_rem;
        end else if (div_rem == '0) begin
            fix.q = -$signed(qu);
            fix.r = '0;
        end else begin
            fix.q = $signed(~qu);
            fix.r = dsel - div_rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= F_IDLE;
            op_reg       <= OP_X0;
            steps_ok_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                steps_ok_reg <= 1'b0;
            end
            unique case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        row_reg  <= s_cell_row;
                        col_reg  <= s_cell_col;
                        bsz_reg  <= s_box_size;
                        dens_reg <= (s_density > DENS_W'(MAX_DENSITY)) ?
                                    DENS_W'(MAX_DENSITY) : s_density;
                        rr_reg   <= (s_ratio_root == '0) ? ROOT_W'(1) : s_ratio_root;
                        if (s_density == '0) begin
                            state_reg <= F_IDLE;
                        end else if (steps_ok_reg) begin
                            state_reg <= F_SHIFT;
                        end else begin
                            state_reg <= F_SX;
                        end
                    end
                end
                F_SX: begin
                    if (derive) begin
                        state_reg <= F_SX_W;
                    end else begin
                        sx_reg    <= {1'b0, cfg.step_x, 12'b0};
                        sy_reg    <= {1'b0, cfg.step_y, 12'b0};
                        state_reg <= F_AVG;
                    end
                end
                F_SX_W: begin
                    if (div_done) begin
                        sx_reg    <= div_quo[STEPQ_W-1:0];
                        state_reg <= F_SY;
                    end
                end
                F_SY: state_reg <= F_SY_W;
                F_SY_W: begin
                    if (div_done) begin
                        sy_reg    <= div_quo[STEPQ_W-1:0];
                        state_reg <= F_AVG;
                    end
                end
                F_AVG: begin
                    avg_reg      <= AVG_W'(({1'b0, sx_reg} + {1'b0, sy_reg}) >> 17);
                    steps_ok_reg <= 1'b1;
                    state_reg    <= F_SHIFT;
                end
                F_SHIFT: state_reg <= F_SHIFT_W;
                F_SHIFT_W: begin
                    if (div_done) begin
                        shift_reg <= div_quo[AVG_W-1:0];
                        state_reg <= F_MULX_LO;
                    end
                end
                F_MULX_LO: begin
                    prod_reg  <= mlo_x;
                    state_reg <= F_MULX_HI;
                end
                F_MULX_HI: begin
                    cx_reg    <= CX_W'(prod_reg) + {mhi_x, {SPLIT{1'b0}}};
                    state_reg <= F_MULY_LO;
                end
                F_MULY_LO: begin
                    prod_reg  <= mlo_y;
                    state_reg <= F_MULY_HI;
                end
                F_MULY_HI: begin
                    cy_reg    <= CX_W'(prod_reg) + {mhi_y, {SPLIT{1'b0}}};
                    state_reg <= F_HH;
                end
                F_HH: state_reg <= F_HH_W;
                F_HH_W: begin
                    if (div_done) begin
                        hh_reg    <= div_quo[HH_W-1:0];
                        state_reg <= F_DC;
                    end
                end
                F_DC: begin
                    dcx_reg   <= $signed(SN_W'(cx_reg)) - $signed(SN_W'(off));
                    dcy_reg   <= $signed(SN_W'(cy_reg)) - $signed(SN_W'(off));
                    hw_reg    <= {(SIZE_W+ROOT_W)'(bsz_reg) * (SIZE_W+ROOT_W)'(rr_reg), 7'b0};
                    op_reg    <= OP_X0;
                    state_reg <= F_PREP;
                end
                F_PREP: begin
                    num_reg   <= num_next;
                    state_reg <= F_GO;
                end
                F_GO: state_reg <= F_WAIT;
                F_WAIT: begin
                    if (div_done) begin
                        res_reg[op_reg] <= fix;
                        if (op_reg == OP_IY) begin
                            state_reg <= F_PUSH;
                        end else begin
                            op_reg    <= fd_op_t'(op_reg + 3'd1);
                            state_reg <= F_PREP;
                        end
                    end
                end
                F_PUSH: begin
                    if (job_ready) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    assign s_ready   = aresetn && (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_PUSH);
    assign job.x0    = res_reg[OP_X0];
    assign job.x1    = res_reg[OP_X1];
    assign job.y0    = res_reg[OP_Y0];
    assign job.y1    = res_reg[OP_Y1];
    assign job.ix    = res_reg[OP_IX];
    assign job.iy    = res_reg[OP_IY];
    assign job.dx    = dx;
    assign job.dy    = dy;
    assign job.dens  = dens_reg;

endmodule
`default_nettype wire

>>> rtl/dpb_fifo.sv
`default_nettype none
module dpb_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               wr_valid,
    output logic                    wr_ready,
    input  wire dpb_pkg::box_job_t  wr_data,
    output logic                    rd_valid,
    input  wire logic               rd_ready,
    output dpb_pkg::box_job_t       rd_data
);
    import dpb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    box_job_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

>>> rtl/dpb_back.sv
`default_nettype none
module dpb_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         job_valid,
    output logic                              job_ready,
    input  wire dpb_pkg::box_job_t            job,
    input  wire logic                         clip,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [dpb_pkg::COORD_W-1:0] m_box_xmin,
    output logic signed [dpb_pkg::COORD_W-1:0] m_box_ymin,
    output logic signed [dpb_pkg::COORD_W-1:0] m_box_xmax,
    output logic signed [dpb_pkg::COORD_W-1:0] m_box_ymax,
    output logic                              m_last_box
);
    import dpb_pkg::*;

    function automatic qr_t qr_add(qr_t a, qr_t inc, logic [DVS_W-1:0] d);
        logic [DVS_W:0] s;
        qr_t            o;
        s = {1'b0, a.r} + {1'b0, inc.r};
        if (s >= {1'b0, d}) begin
            o.r = DVS_W'(s - {1'b0, d});
            o.q = a.q + inc.q + QUO_W'(1);
        end else begin
            o.r = s[DVS_W-1:0];
            o.q = a.q + inc.q;
        end
        return o;
    endfunction

    function automatic logic [COORD_W-1:0] finish_lo(logic signed [QUO_W-1:0] q, logic c);
        logic signed [QUO_W-1:0] v;
        v = q;
        if (v < 0) v = '0;
        if (v > SAT_HI_Q) v = SAT_HI_Q;
        if (c && v > ONE_Q) v = ONE_Q;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] finish_hi(logic signed [QUO_W-1:0] q, logic c);
        logic signed [QUO_W-1:0] v;
        v = q;
        if (v > ONE_Q) v = ONE_Q;
        if (v < SAT_LO_Q) v = SAT_LO_Q;
        if (c && v < 0) v = '0;
        return v[COORD_W-1:0];
    endfunction

    box_job_t         job_reg;
    logic             busy_reg;
    logic [IDX_W-1:0] di_reg, dj_reg;
    qr_t              x0_reg, x1_reg, y0_reg, y1_reg;

    logic             m_valid_reg, m_last_reg;
    logic [COORD_W-1:0] xmin_reg, ymin_reg, xmax_reg, ymax_reg;

    logic emit, row_end, col_end;

    assign job_ready = !busy_reg;
    assign emit      = busy_reg && (!m_valid_reg || m_ready);
    assign col_end   = ({1'b0, dj_reg} == job_reg.dens - 1'b1);
    assign row_end   = ({1'b0, di_reg} == job_reg.dens - 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            di_reg      <= '0;
            dj_reg      <= '0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (!busy_reg) begin
                if (job_valid) begin
                    busy_reg <= 1'b1;
                    di_reg   <= '0;
                    dj_reg   <= '0;
                end
            end else if (emit) begin
                if (col_end) begin
                    dj_reg <= '0;
                    if (row_end) begin
                        busy_reg <= 1'b0;
                    end else begin
                        di_reg <= di_reg + 1'b1;
                    end
                end else begin
                    dj_reg <= dj_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg) begin
            if (job_valid) begin
                job_reg <= job;
                x0_reg  <= job.x0;
                x1_reg  <= job.x1;
                y0_reg  <= job.y0;
                y1_reg  <= job.y1;
            end
        end else if (emit) begin
            if (col_end) begin
                // next sub-row: x restarts, y moves one shift down
                x0_reg <= job_reg.x0;
                x1_reg <= job_reg.x1;
                y0_reg <= qr_add(y0_reg, job_reg.iy, job_reg.dy);
                y1_reg <= qr_add(y1_reg, job_reg.iy, job_reg.dy);
            end else begin
                x0_reg <= qr_add(x0_reg, job_reg.ix, job_reg.dx);
                x1_reg <= qr_add(x1_reg, job_reg.ix, job_reg.dx);
            end
        end
        if (emit) begin
            xmin_reg   <= finish_lo(x0_reg.q, clip);
            ymin_reg   <= finish_lo(y0_reg.q, clip);
            xmax_reg   <= finish_hi(x1_reg.q, clip);
            ymax_reg   <= finish_hi(y1_reg.q, clip);
            m_last_reg <= col_end && row_end;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_box_xmin = $signed(xmin_reg);
    assign m_box_ymin = $signed(ymin_reg);
    assign m_box_xmax = $signed(xmax_reg);
    assign m_box_ymax = $signed(ymax_reg);
    assign m_last_box = m_last_reg;

endmodule
`default_nettype wire

>>> rtl/density_prior_box_generator_top.sv
// Front setup per accepted beat runs on the shared one-bit-per-cycle divider: with cached
// cell steps, six full-width floor divisions, one for the half height and one for the shift;
// two more divisions when the steps are derived again after a register write, none when
// both explicit steps are taken. Zero-density beats are accepted and make no job.
// Back end: density^2 boxes at one per cycle while m_ready does not stall, after the job
// is loaded; a 2-entry queue overlaps front and back end. Sync reset.
`default_nettype none
module density_prior_box_generator_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [dpb_pkg::CIDX_W-1:0]    cfg_index,
    input  wire logic [dpb_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [dpb_pkg::ROW_W-1:0]     s_cell_row,
    input  wire logic [dpb_pkg::ROW_W-1:0]     s_cell_col,
    input  wire logic [dpb_pkg::SIZE_W-1:0]    s_box_size,
    input  wire logic [dpb_pkg::DENS_W-1:0]    s_density,
    input  wire logic [dpb_pkg::ROOT_W-1:0]    s_ratio_root,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [dpb_pkg::COORD_W-1:0] m_box_xmin,
    output logic signed [dpb_pkg::COORD_W-1:0] m_box_ymin,
    output logic signed [dpb_pkg::COORD_W-1:0] m_box_xmax,
    output logic signed [dpb_pkg::COORD_W-1:0] m_box_ymax,
    output logic                               m_last_box
);
    import dpb_pkg::*;

    cfg_t     cfg_reg;
    logic     cfg_wr;
    box_job_t fq_in, fq_out;
    logic     fq_in_valid, fq_in_ready, fq_out_valid, fq_out_ready;

    assign cfg_ready = aresetn;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width   <= IMG_W'(300);
            cfg_reg.image_height  <= IMG_W'(300);
            cfg_reg.fmap_width    <= FEAT_W'(19);
            cfg_reg.fmap_height   <= FEAT_W'(19);
            cfg_reg.step_x        <= '0;
            cfg_reg.step_y        <= '0;
            cfg_reg.center_offset <= OFS_W'(128);
            cfg_reg.clip_enable   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_data[IMG_W-1:0];
                REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= cfg_data[IMG_W-1:0];
                REG_FMAP_WIDTH:    cfg_reg.fmap_width    <= cfg_data[FEAT_W-1:0];
                REG_FMAP_HEIGHT:   cfg_reg.fmap_height   <= cfg_data[FEAT_W-1:0];
                REG_STEP_X:        cfg_reg.step_x        <= cfg_data[STEP_W-1:0];
                REG_STEP_Y:        cfg_reg.step_y        <= cfg_data[STEP_W-1:0];
                REG_CENTER_OFFSET: cfg_reg.center_offset <= cfg_data[OFS_W-1:0];
                REG_CLIP_ENABLE:   cfg_reg.clip_enable   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    dpb_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_row   (s_cell_row),
        .s_cell_col   (s_cell_col),
        .s_box_size   (s_box_size),
        .s_density    (s_density),
        .s_ratio_root (s_ratio_root),
        .cfg          (cfg_reg),
        .cfg_wr       (cfg_wr),
        .job_valid    (fq_in_valid),
        .job_ready    (fq_in_ready),
        .job          (fq_in)
    );

    dpb_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_in_valid),
        .wr_ready (fq_in_ready),
        .wr_data  (fq_in),
        .rd_valid (fq_out_valid),
        .rd_ready (fq_out_ready),
        .rd_data  (fq_out)
    );

    dpb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (fq_out_valid),
        .job_ready  (fq_out_ready),
        .job        (fq_out),
        .clip       (cfg_reg.clip_enable),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_box_xmin (m_box_xmin),
        .m_box_ymin (m_box_ymin),
        .m_box_xmax (m_box_xmax),
        .m_box_ymax (m_box_ymax),
        .m_last_box (m_last_box)
    );

endmodule
`default_nettype wire

>>> tb/density_prior_box_generator_top_tb.sv
`default_nettype none
module density_prior_box_generator_top_tb;
    import dpb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int HOLD_CYCLES    = 3000;

    typedef struct {
        logic signed [COORD_W-1:0] xmin;
        logic signed [COORD_W-1:0] ymin;
        logic signed [COORD_W-1:0] xmax;
        logic signed [COORD_W-1:0] ymax;
        logic                      last;
    } anchor_t;

    typedef struct {
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [SIZE_W-1:0] bsz;
        logic [DENS_W-1:0] dens;
        logic [ROOT_W-1:0] root;
        int                n_boxes;  // -1: left to the predictor
    } cell_req_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [ROW_W-1:0] s_cell_row = '0;
    logic [ROW_W-1:0] s_cell_col = '0;
    logic [SIZE_W-1:0] s_box_size = '0;
    logic [DENS_W-1:0] s_density = '0;
    logic [ROOT_W-1:0] s_ratio_root = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [COORD_W-1:0] m_box_xmin, m_box_ymin, m_box_xmax, m_box_ymax;
    logic m_last_box;

    cfg_t    regs;
    anchor_t anchor_q[$];
    int      errors = 0;
    int      boxes_seen = 0;
    int      idle_cycles = 0;
    bit      hold_done = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    density_prior_box_generator_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cell_row(s_cell_row), .s_cell_col(s_cell_col),
        .s_box_size(s_box_size), .s_density(s_density), .s_ratio_root(s_ratio_root),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_box_xmin(m_box_xmin), .m_box_ymin(m_box_ymin),
        .m_box_xmax(m_box_xmax), .m_box_ymax(m_box_ymax),
        .m_last_box(m_last_box)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint nz(longint v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    function automatic logic signed [COORD_W-1:0] saturate_clip(longint v);
        if (v > 262143) v = 262143;
        if (v < -262144) v = -262144;
        if (regs.clip_enable) begin
            if (v < 0) v = 0;
            if (v > 65536) v = 65536;
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic void apply_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_IMAGE_WIDTH:   regs.image_width   = val[IMG_W-1:0];
            REG_IMAGE_HEIGHT:  regs.image_height  = val[IMG_W-1:0];
            REG_FMAP_WIDTH:    regs.fmap_width    = val[FEAT_W-1:0];
            REG_FMAP_HEIGHT:   regs.fmap_height   = val[FEAT_W-1:0];
            REG_STEP_X:        regs.step_x        = val;
            REG_STEP_Y:        regs.step_y        = val;
            REG_CENTER_OFFSET: regs.center_offset = val[OFS_W-1:0];
            REG_CLIP_ENABLE:   regs.clip_enable   = val[0];
            default: ;
        endcase
    endfunction

    // queues the expected anchors of one cell beat, returns their count
    function automatic int predict_anchors(cell_req_t c);
        longint iw, ih, sx, sy, avg, shift, cx, cy, dcx, dcy, hw, hh, dx, dy, px, py;
        longint x0, y0, x1, y1, rr, d;
        anchor_t a;
        int n;
        n = 0;
        d = c.dens;
        if (d == 0) return 0;
        if (d > MAX_DENSITY) d = MAX_DENSITY;
        rr = nz(c.root);
        iw = nz(regs.image_width);
        ih = nz(regs.image_height);
        if (regs.step_x == 0 || regs.step_y == 0) begin
            sx = (iw << 16) / nz(regs.fmap_width);
            sy = (ih << 16) / nz(regs.fmap_height);
        end else begin
            sx = longint'(regs.step_x) << 12;
            sy = longint'(regs.step_y) << 12;
        end
        avg = (sx + sy) >> 17;
        shift = avg / d;
        cx = ((longint'(c.col) << 8) + regs.center_offset) * sx;
        cy = ((longint'(c.row) << 8) + regs.center_offset) * sy;
        dcx = cx - (avg << 23) + (shift << 23);
        dcy = cy - (avg << 23) + (shift << 23);
        hw = (longint'(c.bsz) * rr) << 7;
        hh = (longint'(c.bsz) << 31) / rr;
        dx = iw << 8;
        dy = ih << 8;
        for (longint i = 0; i < d; i++) begin
            for (longint j = 0; j < d; j++) begin
                px = dcx + ((j * shift) << 24);
                py = dcy + ((i * shift) << 24);
                x0 = floor_div(px - hw, dx);
                y0 = floor_div(py - hh, dy);
                x1 = floor_div(px + hw, dx);
                y1 = floor_div(py + hh, dy);
                if (x0 < 0) x0 = 0;
                if (y0 < 0) y0 = 0;
                if (x1 > 65536) x1 = 65536;
                if (y1 > 65536) y1 = 65536;
                a.xmin = saturate_clip(x0);
                a.ymin = saturate_clip(y0);
                a.xmax = saturate_clip(x1);
                a.ymax = saturate_clip(y1);
                a.last = (i == d - 1 && j == d - 1);
                anchor_q = {anchor_q, a};
                n++;
            end
        end
        return n;
    endfunction

    // leaves cfg_valid high; the caller drops it after the last write of a group
    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(idx, val);
        @(negedge aclk);
    endtask

    // block must be idle before any register write
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (anchor_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic send_cell(cell_req_t c);
        int gap, n;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cell_row   <= c.row;
        s_cell_col   <= c.col;
        s_box_size   <= c.bsz;
        s_density    <= c.dens;
        s_ratio_root <= c.root;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n = predict_anchors(c);
        if (c.n_boxes >= 0 && n != c.n_boxes) begin
            $error("box count: expected %0d actual %0d", c.n_boxes, n);
            errors++;
        end
        @(negedge aclk);
    endtask

    function automatic cell_req_t random_cell();
        cell_req_t c;
        int r;
        c.row = ROW_W'($urandom);
        c.col = ROW_W'($urandom);
        if ($urandom_range(0, 3) == 0) c.row = ROW_W'($urandom_range(0, 20));
        if ($urandom_range(0, 3) == 0) c.col = ROW_W'($urandom_range(0, 20));
        c.bsz = SIZE_W'($urandom);
        if ($urandom_range(0, 1) == 0) c.bsz = SIZE_W'($urandom_range(16, 4000));
        r = $urandom_range(0, 99);
        if (r < 4) c.dens = '0;
        else if (r < 80) c.dens = DENS_W'($urandom_range(1, 4));
        else if (r < 92) c.dens = DENS_W'($urandom_range(5, 8));
        else c.dens = DENS_W'($urandom_range(9, 15));
        c.root = ROOT_W'($urandom);
        if ($urandom_range(0, 1) == 0) c.root = ROOT_W'($urandom_range(2048, 8192));
        if ($urandom_range(0, 40) == 0) c.root = '0;
        c.n_boxes = -1;
        return c;
    endfunction

    task automatic random_config();
        logic [CFG_W-1:0] v;
        for (int i = 0; i < 8; i++) begin
            case (i)
                REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT:
                    v = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom) :
                                                      CFG_W'($urandom_range(1, 4096));
                REG_FMAP_WIDTH, REG_FMAP_HEIGHT:
                    v = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom) :
                                                      CFG_W'($urandom_range(1, 64));
                REG_STEP_X, REG_STEP_Y:
                    v = ($urandom_range(0, 2) == 0) ? '0 : CFG_W'($urandom);
                REG_CENTER_OFFSET: v = CFG_W'($urandom);
                default: v = CFG_W'($urandom);
            endcase
            write_reg(CIDX_W'(i), v);
        end
        cfg_valid <= 1'b0;
    endtask

    cell_req_t directed [] = '{
        '{0, 0, 0, 0, 1, 0},             // zero density: no boxes
        '{0, 0, 16'h0400, 1, 16'h1000, 1},
        '{10'h3FF, 10'h3FF, 16'hFFFF, 8, 16'hFFFF, 64},
        '{0, 10'h3FF, 16'h1000, 15, 16'h1000, 64},  // clamps to max density
        '{5, 7, 16'h0800, 2, 0, 4},      // zero root taken as one
        '{18, 18, 16'h1000, 4, 16'h16A1, 16},
        '{3, 9, 16'h0001, 3, 16'h0001, 9},
        '{10'h2AA, 10'h155, 16'hAAAA, 5, 16'h5555, 25},
        '{10'h155, 10'h2AA, 16'h5555, 6, 16'hAAAA, 36},
        '{1, 1, 16'h7FFF, 7, 16'h8000, 49},
        '{0, 0, 16'hFFFF, 1, 16'h0001, 1}
    };

    initial begin
        regs = '{image_width: 300, image_height: 300, fmap_width: 19,
                 fmap_height: 19, step_x: 0, step_y: 0, center_offset: 128,
                 clip_enable: 0};
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[k]) send_cell(directed[k]);
        wait_drained();

        // extremes: tiny image, big explicit steps, clipping, masked and stray writes
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        write_reg(REG_FMAP_WIDTH, 1024);
        write_reg(REG_FMAP_HEIGHT, 1);
        write_reg(REG_STEP_X, 16'hFFFF);
        write_reg(REG_STEP_Y, 1);
        write_reg(REG_CENTER_OFFSET, 255);
        write_reg(REG_CLIP_ENABLE, 1);
        write_reg(8'd8, 16'h1234);
        cfg_valid <= 1'b0;
        for (int k = 1; k < directed.size(); k++) send_cell(directed[k]);
        wait_drained();

        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 4096);
        write_reg(REG_FMAP_WIDTH, 0);
        write_reg(REG_FMAP_HEIGHT, 16'hFFFF);
        write_reg(REG_STEP_X, 0);
        write_reg(REG_CENTER_OFFSET, 0);
        write_reg(REG_CLIP_ENABLE, 0);
        cfg_valid <= 1'b0;
        for (int k = 1; k < directed.size(); k++) send_cell(directed[k]);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            random_config();
            for (int k = 0; k < 60; k++) send_cell(random_cell());
            wait_drained();
        end

        if (errors == 0) $display("** density_prior_box_generator_top: PASSED **");
        else $display("** density_prior_box_generator_top: FAILED **");
        $finish;
    end

    // result side: random stalls plus one long hold-off to back up the input
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && boxes_seen >= 200) begin
                hold_done = 1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        anchor_t e;
        if (aresetn && m_valid && m_ready) begin
            boxes_seen++;
            if (anchor_q.size() == 0) begin
                $error("unexpected box beat");
                errors++;
            end else begin
                e = anchor_q.pop_front();
                if (m_box_xmin !== e.xmin) begin
                    $error("box_xmin: expected %0d actual %0d", e.xmin, m_box_xmin);
                    errors++;
                end
                if (m_box_ymin !== e.ymin) begin
                    $error("box_ymin: expected %0d actual %0d", e.ymin, m_box_ymin);
                    errors++;
                end
                if (m_box_xmax !== e.xmax) begin
                    $error("box_xmax: expected %0d actual %0d", e.xmax, m_box_xmax);
                    errors++;
                end
                if (m_box_ymax !== e.ymax) begin
                    $error("box_ymax: expected %0d actual %0d", e.ymax, m_box_ymax);
                    errors++;
                end
                if (m_last_box !== e.last) begin
                    $error("last_box: expected %0d actual %0d", e.last, m_last_box);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** density_prior_box_generator_top: FAILED **");
            $finish;
        end
    end

endmodule
`default_nettype wire

>>> density_prior_box_generator_top.f
rtl/dpb_pkg.sv
rtl/dpb_div.sv
rtl/dpb_front.sv
rtl/dpb_fifo.sv
rtl/dpb_back.sv
rtl/density_prior_box_generator_top.sv
tb/density_prior_box_generator_top_tb.sv
